// ===== rtl/rrfc_pkg.sv =====
`timescale 1ns / 1ps
package rrfc_pkg;

   // reset values of the ring registers
   localparam logic [7:0] RING_START_RESET = 8'd70;
   localparam logic [7:0] RING_STOP_RESET  = 8'd128;

   // frame length limits, byte count includes the header
   localparam logic [15:0] HDR_BYTES      = 16'd4;
   localparam logic [15:0] MIN_BYTE_COUNT = 16'd64;
   localparam logic [15:0] MAX_BYTE_COUNT = 16'd1522;
   localparam logic [3:0]  STATUS_GOOD    = 4'h1;

   localparam int COUNTER_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH          = 2;

   // register index on the configuration port
   localparam logic REG_RING_START = 1'b0;
   localparam logic REG_RING_STOP  = 1'b1;

   typedef enum logic [2:0] {
      OUT_EMPTY      = 3'd0,
      OUT_INDEX_ERR  = 3'd1,
      OUT_SIZE_ERR   = 3'd2,
      OUT_ACCEPTED   = 3'd3,
      OUT_NO_BUFFER  = 3'd4,
      OUT_BAD_STATUS = 3'd5
   } outcome_type;

   // pre-classified header, passed from front to back
   typedef struct packed {
      logic [7:0]  wpage;
      logic [10:0] dlt0;      // link - 1 - (count >> 8)
      logic [10:0] dlt1;      // same, minus one
      logic [10:0] dltn0;     // same, plus ring size
      logic [10:0] dltn1;     // plus ring size, minus one
      logic [7:0]  link_bnd;  // boundary if the link is followed
      logic        size_bad;
      logic        stat_good;
      logic        fifo_bad;
      logic        buf_free;
      logic [10:0] plen;
   } item_type;

endpackage

// ===== rtl/rrfc_front.sv =====
`timescale 1ns / 1ps
module rrfc_front
   import rrfc_pkg::*;
(
   input  logic [7:0]  ring_start,
   input  logic [7:0]  ring_stop,
   input  logic [7:0]  write_page,
   input  logic [7:0]  hdr_status,
   input  logic [7:0]  hdr_next_page,
   input  logic [15:0] hdr_byte_count,
   input  logic        buffer_free,
   output item_type    item
);

   logic [10:0] ring_size;
   logic [10:0] link_dlt;
   logic [7:0]  link_wrap;

   // link offsets against the page span of this frame
   assign ring_size = {3'b000, ring_stop} - {3'b000, ring_start};
   assign link_dlt  = {3'b000, hdr_next_page} - 11'd1 - {3'b000, hdr_byte_count[15:8]};

   // link beyond the ring is taken as ring start
   assign link_wrap = (hdr_next_page >= ring_stop) ? ring_start : hdr_next_page;

   always_comb begin
      item.wpage     = write_page;
      item.dlt0      = link_dlt;
      item.dlt1      = link_dlt - 11'd1;
      item.dltn0     = link_dlt + ring_size;
      item.dltn1     = link_dlt + ring_size - 11'd1;
      item.link_bnd  = (link_wrap <= ring_start) ? (ring_stop - 8'd1) : (link_wrap - 8'd1);
      item.size_bad  = (hdr_byte_count < MIN_BYTE_COUNT) || (hdr_byte_count > MAX_BYTE_COUNT);
      item.stat_good = (hdr_status[3:0] == STATUS_GOOD);
      item.fifo_bad  = hdr_status[3];
      item.buf_free  = buffer_free;
      item.plen      = 11'(hdr_byte_count - HDR_BYTES);
   end

endmodule

// ===== rtl/rrfc_queue.sv =====
`timescale 1ns / 1ps
module rrfc_queue
   import rrfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(QUEUE_DEPTH);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (cnt_ff == FullCnt);
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/rrfc_back.sv =====
`timescale 1ns / 1ps
module rrfc_back
   import rrfc_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  ring_start,
   input  logic [7:0]  ring_stop,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output outcome_type out_outcome,
   output logic [7:0]  out_frame_page,
   output logic [10:0] out_payload_length,
   output logic [7:0]  out_new_boundary,
   output logic [31:0] out_good_count,
   output logic [31:0] out_index_error_count,
   output logic [31:0] out_size_error_count,
   output logic [31:0] out_fifo_error_count,
   output logic [31:0] out_dropped_count
);

   localparam logic [COUNTER_BITS-1:0] CntMax = '1;

   logic [7:0]              bnd_ff, bnd_in;
   logic [COUNTER_BITS-1:0] good_ff, good_in;
   logic [COUNTER_BITS-1:0] idx_ff, idx_in;
   logic [COUNTER_BITS-1:0] size_ff, size_in;
   logic [COUNTER_BITS-1:0] fifo_ff, fifo_in;
   logic [COUNTER_BITS-1:0] drop_ff, drop_in;
   logic                    out_valid_ff;
   outcome_type             outcome_ff, outcome_in;
   logic [7:0]              frame_ff;
   logic [10:0]             plen_ff, plen_in;

   logic        fire;
   logic [8:0]  bnd_inc;
   logic [7:0]  frame;
   logic [10:0] frame_x;
   logic        link_ok;
   logic [7:0]  own_bnd;
   logic        inc_good, inc_idx, inc_size, inc_fifo, inc_drop;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(
      input logic [COUNTER_BITS-1:0] c,
      input logic                    en
   );
      return (en && (c != CntMax)) ? c + 1'b1 : c;
   endfunction

   function automatic logic [31:0] clip32(input logic [COUNTER_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   assign fire = head_valid && (!out_valid_ff || out_ready);
   assign pop  = fire;

   // read page follows the boundary, wrapping to ring start
   assign bnd_inc = {1'b0, bnd_ff} + 9'd1;
   assign frame   = (bnd_inc >= {1'b0, ring_stop}) ? ring_start : bnd_inc[7:0];
   assign frame_x = {3'b000, frame};
   assign own_bnd = (frame <= ring_start) ? (ring_stop - 8'd1) : (frame - 8'd1);

   // link must land on one of the four legal pages
   assign link_ok = (head_item.dlt0 == frame_x) || (head_item.dlt1 == frame_x)
                 || (head_item.dltn0 == frame_x) || (head_item.dltn1 == frame_x);

   // classify and work out the boundary move
   always_comb begin
      outcome_in = OUT_EMPTY;
      plen_in    = '0;
      bnd_in     = bnd_ff;
      inc_good   = 1'b0;
      inc_idx    = 1'b0;
      inc_size   = 1'b0;
      inc_fifo   = 1'b0;
      inc_drop   = 1'b0;
      if (frame == head_item.wpage) begin
         outcome_in = OUT_EMPTY;
      end else if (!link_ok) begin
         outcome_in = OUT_INDEX_ERR;
         inc_idx    = 1'b1;
         bnd_in     = own_bnd;
      end else if (head_item.size_bad) begin
         outcome_in = OUT_SIZE_ERR;
         inc_size   = 1'b1;
         bnd_in     = head_item.link_bnd;
      end else if (head_item.stat_good) begin
         if (head_item.buf_free) begin
            outcome_in = OUT_ACCEPTED;
            plen_in    = head_item.plen;
            inc_good   = 1'b1;
            bnd_in     = head_item.link_bnd;
         end else begin
            outcome_in = OUT_NO_BUFFER;
            inc_drop   = 1'b1;
         end
      end else begin
         outcome_in = OUT_BAD_STATUS;
         inc_fifo   = head_item.fifo_bad;
         bnd_in     = head_item.link_bnd;
      end
      good_in = sat_inc(good_ff, inc_good);
      idx_in  = sat_inc(idx_ff, inc_idx);
      size_in = sat_inc(size_ff, inc_size);
      fifo_in = sat_inc(fifo_ff, inc_fifo);
      drop_in = sat_inc(drop_ff, inc_drop);
   end

   // ring state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff       <= RING_STOP_RESET - 8'd1;
         good_ff      <= '0;
         idx_ff       <= '0;
         size_ff      <= '0;
         fifo_ff      <= '0;
         drop_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            bnd_ff  <= bnd_in;
            good_ff <= good_in;
            idx_ff  <= idx_in;
            size_ff <= size_in;
            fifo_ff <= fifo_in;
            drop_ff <= drop_in;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         outcome_ff <= outcome_in;
         frame_ff   <= frame;
         plen_ff    <= plen_in;
      end
   end

   assign out_valid             = out_valid_ff;
   assign out_outcome           = outcome_ff;
   assign out_frame_page        = frame_ff;
   assign out_payload_length    = plen_ff;
   assign out_new_boundary      = bnd_ff;
   assign out_good_count        = clip32(good_ff);
   assign out_index_error_count = clip32(idx_ff);
   assign out_size_error_count  = clip32(size_ff);
   assign out_fifo_error_count  = clip32(fifo_ff);
   assign out_dropped_count     = clip32(drop_ff);

endmodule

// ===== rtl/receive_ring_frame_checker_core.sv =====
`timescale 1ns / 1ps
// Receive ring frame checker: consumer side of a paged receive ring.
// req_ channel: one frame header per transfer (write page, status, link page,
// byte count, buffer free). rsp_ channel: one result per header with the
// outcome, the page read, payload address and length, the boundary after the
// step and five saturating counters. csr_ is an APB-style port holding ring
// start (0x0) and ring stop (0x4); write it only while no header is in flight.
// Throughput is one header per cycle while rsp_tready is high: the front
// classifies the header into a two-entry queue, the back owns the boundary
// register whose update carries from one header to the next. A header passes
// through the queue and then the output register on its way to rsp_tvalid.
// Reset sets ring start 70, ring stop 128, boundary 127, counters to zero,
// and empties queue and output register. When the receiver holds rsp_tready
// low the result stays in the output register, the queue fills with two more
// headers and then req_tready goes low until the result is taken.
module receive_ring_frame_checker_core
   import rrfc_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // write_page[7:0], hdr_status[15:8], hdr_next_page[23:16],
   // hdr_byte_count[39:24], buffer_free[40], zero[47:41]
   input  logic [47:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // outcome[2:0], frame_page[10:3], payload_address[26:11],
   // payload_length[37:27], new_boundary[45:38], good_count[77:46],
   // index_error_count[109:78], size_error_count[141:110],
   // fifo_error_count[173:142], dropped_count[205:174], zero[207:206]
   output logic [207:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [7:0]  start_ff;
   logic [7:0]  stop_ff;
   logic        csr_wr;
   item_type    front_item;
   item_type    head_item;
   logic        q_full;
   logic        head_valid;
   logic        pop;
   outcome_type res_outcome;
   logic [7:0]  res_frame;
   logic [10:0] res_plen;
   logic [7:0]  res_bnd;
   logic [31:0] res_good, res_idx, res_size, res_fifo, res_drop;
   logic [15:0] res_addr;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= RING_START_RESET;
         stop_ff  <= RING_STOP_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_RING_START) begin
            start_ff <= csr_pwdata[7:0];
         end else begin
            stop_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_RING_STOP) ? {24'd0, stop_ff} : {24'd0, start_ff};

   // header classification
   rrfc_front u_front (
      .ring_start     (start_ff),
      .ring_stop      (stop_ff),
      .write_page     (req_tdata[7:0]),
      .hdr_status     (req_tdata[15:8]),
      .hdr_next_page  (req_tdata[23:16]),
      .hdr_byte_count (req_tdata[39:24]),
      .buffer_free    (req_tdata[40]),
      .item           (front_item)
   );

   assign req_tready = !q_full;

   rrfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // ring state and result register
   rrfc_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .ring_start            (start_ff),
      .ring_stop             (stop_ff),
      .head_valid            (head_valid),
      .head_item             (head_item),
      .pop                   (pop),
      .out_valid             (rsp_tvalid),
      .out_ready             (rsp_tready),
      .out_outcome           (res_outcome),
      .out_frame_page        (res_frame),
      .out_payload_length    (res_plen),
      .out_new_boundary      (res_bnd),
      .out_good_count        (res_good),
      .out_index_error_count (res_idx),
      .out_size_error_count  (res_size),
      .out_fifo_error_count  (res_fifo),
      .out_dropped_count     (res_drop)
   );

   // result packing
   assign res_addr  = {res_frame, 8'd4};
   assign rsp_tdata = {2'b00, res_drop, res_fifo, res_size, res_idx, res_good,
                       res_bnd, res_plen, res_addr, res_frame, res_outcome};

endmodule
